[src/roman_numeral_encoder_core_assert.svh]
// Assertion macros used by the Roman numeral encoder sequencer (rne_emit).
`ifndef ROMAN_NUMERAL_ENCODER_CORE_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clk edge out of reset.
`define RNE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RNE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/rne_pkg.sv]
// Shared types, constants and digit spelling function of the Roman numeral encoder.
`timescale 1ns / 1ps

package rne_pkg;

	localparam int BIN_W    = 34;
	localparam int DIGITS   = 10;
	localparam int BCD_W    = 4 * DIGITS;
	localparam int CHAR_W   = 7;
	localparam int SEQ_MAX  = 8;

	localparam logic [BIN_W-1:0] DEC_LIMIT = 34'd9999999999;

	localparam logic [CHAR_W-1:0] CH_I  = 7'h49;
	localparam logic [CHAR_W-1:0] CH_V  = 7'h56;
	localparam logic [CHAR_W-1:0] CH_X  = 7'h58;
	localparam logic [CHAR_W-1:0] CH_L  = 7'h4C;
	localparam logic [CHAR_W-1:0] CH_C  = 7'h43;
	localparam logic [CHAR_W-1:0] CH_D  = 7'h44;
	localparam logic [CHAR_W-1:0] CH_M  = 7'h4D;
	localparam logic [CHAR_W-1:0] CH_LX = 7'h78;	// lower-case x, error fill
	localparam logic [CHAR_W-1:0] CH_PO = 7'h28;
	localparam logic [CHAR_W-1:0] CH_PC = 7'h29;
	localparam logic [CHAR_W-1:0] CH_SO = 7'h5B;
	localparam logic [CHAR_W-1:0] CH_SC = 7'h5D;
	localparam logic [CHAR_W-1:0] CH_CO = 7'h7B;
	localparam logic [CHAR_W-1:0] CH_CC = 7'h7D;
	localparam logic [CHAR_W-1:0] CH_NUL = 7'h00;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_ERROR,
		MODE_ZERO
	} mode_t;

	typedef struct packed {
		logic  go;
		mode_t mode;
	} emit_cmd_t;

	typedef struct packed {
		logic [3:0]                      len;
		logic [SEQ_MAX-1:0][CHAR_W-1:0] chars;
	} seq_t;

	function automatic seq_t seq_push(input seq_t s, input logic [CHAR_W-1:0] c);
		seq_t r;
		r = s;
		r.chars[s.len[2:0]] = c;
		r.len = s.len + 4'd1;
		return r;
	endfunction

	function automatic seq_t seq_push_big(input seq_t s, input logic [CHAR_W-1:0] c,
			input logic wrap, input logic [CHAR_W-1:0] op, input logic [CHAR_W-1:0] cl);
		seq_t r;
		r = s;
		if (wrap) begin
			r = seq_push(r, op);
			r = seq_push(r, c);
			r = seq_push(r, cl);
		end else begin
			r = seq_push(r, c);
		end
		return r;
	endfunction

	// Characters of digit d at decimal position pos (1 = units).
	function automatic seq_t digit_seq(input logic [3:0] d, input logic [3:0] pos);
		seq_t             s;
		logic [1:0]       rank;
		logic             beyond;
		logic             outer;
		logic [CHAR_W-1:0] unit, five, ten, o_op, o_cl, i_op, i_cl;
		s      = '0;
		rank   = 2'd0;
		outer  = 1'b0;
		o_op   = CH_PO;
		o_cl   = CH_PC;
		i_op   = CH_PO;
		i_cl   = CH_PC;
		case (pos)
			4'd1: rank = 2'd0;
			4'd2: rank = 2'd1;
			4'd3: rank = 2'd2;
			4'd4: rank = 2'd3;
			4'd5, 4'd6, 4'd7: begin
				rank  = 2'(pos - 4'd4);
				outer = 1'b1;
				i_op  = CH_SO;
				i_cl  = CH_SC;
			end
			4'd8, 4'd9, 4'd10: begin
				rank  = 2'(pos - 4'd7);
				outer = 1'b1;
				o_op  = CH_SO;
				o_cl  = CH_SC;
				i_op  = CH_CO;
				i_cl  = CH_CC;
			end
			default: rank = 2'd0;
		endcase
		beyond = (rank == 2'd3);
		case (rank)
			2'd0: begin unit = CH_I; five = CH_V; ten = CH_X; end
			2'd1: begin unit = CH_X; five = CH_L; ten = CH_C; end
			2'd2: begin unit = CH_C; five = CH_D; ten = CH_M; end
			default: begin unit = CH_M; five = CH_V; ten = CH_X; end
		endcase
		if (d != 4'd0 && d <= 4'd9 && pos != 4'd0 && pos <= 4'd10) begin
			if (outer)
				s = seq_push(s, o_op);
			if (d <= 4'd3) begin
				for (int i = 0; i < 3; i++) begin
					if (4'(i) < d)
						s = seq_push(s, unit);
				end
			end else if (d == 4'd4) begin
				s = seq_push(s, unit);
				s = seq_push_big(s, five, beyond, i_op, i_cl);
			end else if (d <= 4'd8) begin
				s = seq_push_big(s, five, beyond, i_op, i_cl);
				for (int i = 0; i < 3; i++) begin
					if (4'(i) < d - 4'd5)
						s = seq_push(s, unit);
				end
			end else begin
				s = seq_push(s, unit);
				s = seq_push_big(s, ten, beyond, i_op, i_cl);
			end
			if (outer)
				s = seq_push(s, o_cl);
		end
		return s;
	endfunction

endpackage

[src/rne_bcd.sv]
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
`timescale 1ns / 1ps

module rne_bcd import rne_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [BIN_W-1:0]  bin,
	output logic              done,
	output logic [BCD_W-1:0]  digits
);

	logic [BIN_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(BIN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[BIN_W-1]};
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;

endmodule

[src/rne_emit.sv]
// Character sequencer: walks decimal digits from the top and drives the output item register.
`timescale 1ns / 1ps

module rne_emit import rne_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  emit_cmd_t         cmd,
	input  logic [BCD_W-1:0]  digits,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [CHAR_W-1:0] char_code,
	output logic              last,
	output logic              error,
	output logic              empty_res,
	output logic              done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NORM,
		ST_ERR,
		ST_ZERO
	} state_t;

	state_t            state_q;
	logic [BCD_W-1:0]  digits_q;
	logic [3:0]        pos_q;
	logic [2:0]        step_q;
	logic              valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              err_q;
	logic              empty_q;

	seq_t seq;
	logic slot_free;
	logic top_zero;
	logic rest_nz;
	logic digit_end;
	logic fin;
	logic load;

	assign seq       = digit_seq(digits_q[BCD_W-1 -: 4], pos_q);
	assign slot_free = !valid_q || m_tready;
	assign top_zero  = (digits_q[BCD_W-1 -: 4] == 4'd0);
	assign rest_nz   = |digits_q[BCD_W-5:0];
	assign digit_end = ({1'b0, step_q} == seq.len - 4'd1);

	// fin: the final item of this number is loaded this cycle
	always_comb begin
		case (state_q)
			ST_NORM: fin = slot_free && !top_zero && digit_end && !rest_nz;
			ST_ERR:  fin = slot_free && (step_q == 3'd3);
			ST_ZERO: fin = slot_free;
			default: fin = 1'b0;
		endcase
	end

	// load: a new item enters the output register this cycle
	always_comb begin
		case (state_q)
			ST_NORM: load = slot_free && !top_zero;
			ST_ERR:  load = slot_free;
			ST_ZERO: load = slot_free;
			default: load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			step_q  <= '0;
			pos_q   <= '0;
		end else begin
			valid_q <= load || (valid_q && !m_tready);
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					pos_q  <= 4'(DIGITS);
					if (cmd.go) begin
						case (cmd.mode)
							MODE_NORMAL: state_q <= ST_NORM;
							MODE_ERROR:  state_q <= ST_ERR;
							MODE_ZERO:   state_q <= ST_ZERO;
							default:     state_q <= ST_IDLE;
						endcase
					end
				end
				ST_NORM: begin
					if (top_zero) begin
						pos_q <= pos_q - 4'd1;
					end else if (slot_free) begin
						if (digit_end) begin
							step_q <= '0;
							pos_q  <= pos_q - 4'd1;
						end else begin
							step_q <= step_q + 3'd1;
						end
						if (fin)
							state_q <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (slot_free) begin
						step_q  <= step_q + 3'd1;
						if (fin)
							state_q <= ST_IDLE;
					end
				end
				ST_ZERO: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload: digit shift line and output item
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.go)
			digits_q <= digits;
		else if (state_q == ST_NORM && (top_zero || (slot_free && digit_end)))
			digits_q <= {digits_q[BCD_W-5:0], 4'd0};
		case (state_q)
			ST_NORM: begin
				if (!top_zero && slot_free) begin
					char_q  <= seq.chars[step_q];
					last_q  <= fin;
					err_q   <= 1'b0;
					empty_q <= 1'b0;
				end
			end
			ST_ERR: begin
				if (slot_free) begin
					char_q  <= CH_LX;
					last_q  <= fin;
					err_q   <= 1'b1;
					empty_q <= 1'b0;
				end
			end
			ST_ZERO: begin
				if (slot_free) begin
					char_q  <= CH_NUL;
					last_q  <= 1'b1;
					err_q   <= 1'b0;
					empty_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid  = valid_q;
	assign char_code = char_q;
	assign last      = last_q;
	assign error     = err_q;
	assign empty_res = empty_q;
	assign done      = fin;

`include "roman_numeral_encoder_core_assert.svh"

	`RNE_ASSERT_NOW(a_go_when_idle, cmd.go, state_q == ST_IDLE, "start while still emitting")
	`RNE_ASSERT_NOW(a_err_not_empty, valid_q && err_q, !empty_q, "error item flagged empty")
	`RNE_ASSERT_NOW(a_empty_is_last, valid_q && empty_q, last_q, "empty item not last")
	`RNE_ASSERT_NEXT(a_fin_idle, fin, state_q == ST_IDLE && valid_q && last_q,
		"final item not loaded")

endmodule

[src/roman_numeral_encoder_core.sv]
// Top level of the Roman numeral encoder: input handshake, range check and dispatch.
`timescale 1ns / 1ps

// Converts one unsigned 34-bit number per input item into its Roman numeral, one ASCII
// character per output item, most significant digit first; tlast marks the final character.
// A value above 9999999999 gives four 'x' items with the error flag; zero gives one item
// with the empty flag. Otherwise the number goes through a bit-serial binary-to-BCD
// shifter, then the sequencer skips each zero digit above the lowest non-zero one and
// emits one character per cycle while the output is not stalled, up to 58 characters
// in all. The next item is taken as soon as the final character of the current one
// sits in the output register.
module roman_numeral_encoder_core import rne_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,	// [33:0] number, [39:34] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,	// [6:0] char_code, [7] zero
	output logic        m_tlast,
	output logic [1:0]  m_tuser		// [0] error, [1] empty_res
);

	logic              busy_q;
	logic              accept;
	logic [BIN_W-1:0]  number;
	logic              too_big;
	logic              is_zero;
	logic              bcd_start;
	logic              bcd_done;
	logic [BCD_W-1:0]  bcd_digits;
	emit_cmd_t         cmd;
	logic              emit_done;
	logic [CHAR_W-1:0] char_code;
	logic              error;
	logic              empty_res;

	assign s_tready  = !busy_q;
	assign accept    = s_tvalid && s_tready;
	assign number    = s_tdata[BIN_W-1:0];
	assign too_big   = (number > DEC_LIMIT);
	assign is_zero   = (number == '0);
	assign bcd_start = accept && !too_big && !is_zero;

	always_comb begin
		cmd.go = bcd_done || (accept && (too_big || is_zero));
		if (bcd_done)
			cmd.mode = MODE_NORMAL;
		else if (too_big)
			cmd.mode = MODE_ERROR;
		else
			cmd.mode = MODE_ZERO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (emit_done) begin
			busy_q <= 1'b0;
		end
	end

	rne_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.bin    (number),
		.done   (bcd_done),
		.digits (bcd_digits)
	);

	rne_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.digits    (bcd_digits),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.char_code (char_code),
		.last      (m_tlast),
		.error     (error),
		.empty_res (empty_res),
		.done      (emit_done)
	);

	assign m_tdata = {1'b0, char_code};
	assign m_tuser = {empty_res, error};

endmodule

[verif/testbench.sv]
// Self-checking testbench for the Roman numeral encoder core.
`timescale 1ns / 1ps

module testbench import rne_pkg::*;;

	localparam int CYCLE_LIMIT = 800000;
	localparam int HOLD_AT     = 40;	// items taken before the long output hold-off
	localparam int HOLD_LEN    = 400;
	localparam int TAIL_CYCLES = 150;
	localparam int RANDOM_ITEMS = 250;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
		logic              error;
		logic              empty_res;
	} roman_glyph_t;

	typedef struct packed {
		logic [BIN_W-1:0] value;
		logic             drain_first;	// wait for all glyphs before offering
	} number_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;

	number_item_t numbers_to_send[$];
	roman_glyph_t pending_glyphs[$];

	int items_taken;
	int total_items;
	int calm_from;
	int gap_left;
	int stall_left;
	int hold_left;
	logic hold_done;
	int cycle_count;
	int fail_count;
	logic offer;
	roman_glyph_t want;

	roman_numeral_encoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- glyph prediction

	function automatic void add_glyph(input logic [CHAR_W-1:0] c);
		roman_glyph_t g;
		g.char_code = c;
		g.last      = 1'b0;
		g.error     = 1'b0;
		g.empty_res = 1'b0;
		pending_glyphs = {pending_glyphs, g};
	endfunction

	// Five or ten letter; at the thousands rank of each tier it is bracketed
	function automatic void add_wide(input logic [CHAR_W-1:0] c, input logic wrap,
			input logic [CHAR_W-1:0] op, input logic [CHAR_W-1:0] cl);
		if (wrap) begin
			add_glyph(op);
			add_glyph(c);
			add_glyph(cl);
		end else begin
			add_glyph(c);
		end
	endfunction

	function automatic void spell_digit(input int d, input int pos);
		int rank;
		logic has_outer;
		logic [CHAR_W-1:0] unit, five, ten, outer_op, outer_cl, inner_op, inner_cl;
		if (d == 0)
			return;
		has_outer = 1'b0;
		outer_op  = CH_PO;
		outer_cl  = CH_PC;
		inner_op  = CH_PO;
		inner_cl  = CH_PC;
		if (pos <= 4) begin
			rank = pos - 1;
		end else if (pos <= 7) begin
			rank      = pos - 4;
			has_outer = 1'b1;
			inner_op  = CH_SO;
			inner_cl  = CH_SC;
		end else begin
			rank      = pos - 7;
			has_outer = 1'b1;
			outer_op  = CH_SO;
			outer_cl  = CH_SC;
			inner_op  = CH_CO;
			inner_cl  = CH_CC;
		end
		case (rank)
			0: begin unit = CH_I; five = CH_V; ten = CH_X; end
			1: begin unit = CH_X; five = CH_L; ten = CH_C; end
			2: begin unit = CH_C; five = CH_D; ten = CH_M; end
			default: begin unit = CH_M; five = CH_V; ten = CH_X; end
		endcase
		if (has_outer)
			add_glyph(outer_op);
		if (d <= 3) begin
			for (int i = 0; i < d; i++)
				add_glyph(unit);
		end else if (d == 4) begin
			add_glyph(unit);
			add_wide(five, rank == 3, inner_op, inner_cl);
		end else if (d <= 8) begin
			add_wide(five, rank == 3, inner_op, inner_cl);
			for (int i = 5; i < d; i++)
				add_glyph(unit);
		end else begin
			add_glyph(unit);
			add_wide(ten, rank == 3, inner_op, inner_cl);
		end
		if (has_outer)
			add_glyph(outer_cl);
	endfunction

	function automatic void spell_roman(input logic [BIN_W-1:0] n);
		longint unsigned v;
		int dig[10];
		int ndig;
		roman_glyph_t g;
		if (n > DEC_LIMIT) begin
			for (int k = 0; k < 4; k++) begin
				g.char_code = CH_LX;
				g.last      = (k == 3);
				g.error     = 1'b1;
				g.empty_res = 1'b0;
				pending_glyphs = {pending_glyphs, g};
			end
		end else if (n == '0) begin
			g.char_code = CH_NUL;
			g.last      = 1'b1;
			g.error     = 1'b0;
			g.empty_res = 1'b1;
			pending_glyphs = {pending_glyphs, g};
		end else begin
			v    = n;
			ndig = 0;
			for (int p = 0; p < 10; p++) begin
				dig[p] = int'(v % 10);
				if (v != 0)
					ndig = p + 1;
				v = v / 10;
			end
			for (int p = ndig; p >= 1; p--)
				spell_digit(dig[p-1], p);
			pending_glyphs[pending_glyphs.size()-1].last = 1'b1;
		end
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	task automatic queue_number(input logic [BIN_W-1:0] v, input logic drain);
		number_item_t it;
		it.value       = v;
		it.drain_first = drain;
		numbers_to_send = {numbers_to_send, it};
	endtask

	function automatic logic [BIN_W-1:0] random_number();
		int sel;
		int ndig;
		int d;
		longint unsigned acc;
		logic [BIN_W-1:0] v;
		sel = $urandom_range(99);
		if (sel < 8) begin
			v = {2'($urandom_range(3)), 32'($urandom)};
			while (v <= DEC_LIMIT)
				v = {2'($urandom_range(3)), 32'($urandom)};
		end else if (sel < 12) begin
			v = '0;
		end else if (sel < 17) begin
			v = {2'($urandom_range(3)), 32'($urandom)};
		end else begin
			// decimal digits drawn directly, zeros sprinkled in
			ndig = $urandom_range(1, 10);
			acc  = 0;
			for (int p = 0; p < ndig; p++) begin
				if (p == 0)
					d = $urandom_range(1, 9);
				else if ($urandom_range(4) == 0)
					d = 0;
				else
					d = $urandom_range(9);
				acc = acc * 10 + d;
			end
			v = BIN_W'(acc);
		end
		return v;
	endfunction

	function automatic logic idling_allowed();
		return (items_taken < calm_from) && (((items_taken / 32) % 4) != 3);
	endfunction

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid    <= 1'b0;
			s_tdata     <= '0;
			items_taken <= 0;
			gap_left    = 0;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				spell_roman(s_tdata[BIN_W-1:0]);
				items_taken <= items_taken + 1;
				offer = 1'b0;
				if (idling_allowed() && $urandom_range(3) == 0)
					gap_left = $urandom_range(1, 4);
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (numbers_to_send.size() > 0 &&
						!(numbers_to_send[0].drain_first && pending_glyphs.size() != 0)) begin
					s_tdata <= {6'b0, numbers_to_send[0].value};
					void'(numbers_to_send.pop_front());
					offer = 1'b1;
				end
			end
			s_tvalid <= offer;
		end
	end

	// ---------------------------------------------------------------- receiver

	// long output hold-off so the core backs up onto its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && items_taken == HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left = 0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idling_allowed() && $urandom_range(5) == 0) begin
			stall_left = $urandom_range(3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_glyphs.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected item: char %h last %b user %b", m_tdata, m_tlast,
							m_tuser);
			end else begin
				want = pending_glyphs.pop_front();
				if (m_tdata !== {1'b0, want.char_code} || m_tlast !== want.last ||
						m_tuser[0] !== want.error || m_tuser[1] !== want.empty_res) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: char %h/%h last %b/%b error %b/%b empty %b/%b",
								{1'b0, want.char_code}, m_tdata, want.last, m_tlast,
								want.error, m_tuser[0], want.empty_res, m_tuser[1]);
				end
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		cycle_count = 0;
		fail_count  = 0;

		// directed: zero, single digits, bracket tiers, largest spellings, error edge
		queue_number(34'd0, 1'b0);
		queue_number(34'd1, 1'b0);
		queue_number(34'd4, 1'b0);
		queue_number(34'd5, 1'b0);
		queue_number(34'd8, 1'b0);
		queue_number(34'd9, 1'b0);
		queue_number(34'd10, 1'b0);
		queue_number(34'd3888, 1'b0);
		queue_number(34'd3999, 1'b0);
		queue_number(34'd4000, 1'b0);
		queue_number(34'd9000, 1'b0);
		queue_number(34'd49999, 1'b0);
		queue_number(34'd5000000, 1'b1);
		queue_number(34'd8000000, 1'b0);
		queue_number(34'd98765432, 1'b0);
		queue_number(34'd1000000000, 1'b0);
		queue_number(34'd8888888888, 1'b0);
		queue_number(34'd9999999999, 1'b0);
		queue_number(34'd10000000000, 1'b0);
		queue_number(34'h3FFFFFFFF, 1'b0);
		queue_number(34'd4444444444, 1'b0);
		queue_number(34'd9090909090, 1'b0);
		queue_number(34'h2AAAAAAAA, 1'b0);
		queue_number(34'h155555555, 1'b0);
		queue_number(34'd1010101010, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++)
			queue_number(random_number(), i == 100);

		total_items = numbers_to_send.size();
		calm_from   = total_items - 40;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (items_taken != total_items || pending_glyphs.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_glyphs.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
